### src/hlmdu_pkg.sv
//------------------------------------------------------------------------------
// hlmdu_pkg
// Shared codes, types and sizes for the HI/LO multiply/divide unit.
//------------------------------------------------------------------------------
package hlmdu_pkg;

    localparam int DATA_W = 64;
    localparam int HALF_W = 32;
    localparam int MODE_W = 4;
    localparam int REG_W  = 5;
    localparam int CNT_W  = 6;

    // Operation codes carried on the mode field.
    localparam logic [MODE_W-1:0] MODE_MFLO   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_MFHI   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_MTLO   = 4'd2;
    localparam logic [MODE_W-1:0] MODE_MTHI   = 4'd3;
    localparam logic [MODE_W-1:0] MODE_MULT   = 4'd4;
    localparam logic [MODE_W-1:0] MODE_MULTU  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_DMULT  = 4'd6;
    localparam logic [MODE_W-1:0] MODE_DMULTU = 4'd7;
    localparam logic [MODE_W-1:0] MODE_DIV    = 4'd8;
    localparam logic [MODE_W-1:0] MODE_DIVU   = 4'd9;
    localparam logic [MODE_W-1:0] MODE_DDIV   = 4'd10;
    localparam logic [MODE_W-1:0] MODE_DDIVU  = 4'd11;

    // Last step index of each multi-cycle phase.
    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(4);
    localparam logic [CNT_W-1:0] CORR_LAST = CNT_W'(1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DATA_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_MUL_CORR,
        S_DIV,
        S_DIV_FIX,
        S_COMMIT
    } t_state;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_LOAD,
        DP_MUL_STEP,
        DP_MUL_CORR,
        DP_DIV_STEP,
        DP_DIV_FIX,
        DP_COMMIT
    } t_dp_op;

    typedef enum logic [1:0] {
        K_MOVE,
        K_MUL,
        K_DIV
    } t_kind;

    typedef struct packed {
        t_dp_op           op;
        logic [CNT_W-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
    } t_dp_status;

endpackage

### src/hi_lo_multiply_divide_unit.sv
//------------------------------------------------------------------------------
// hi_lo_multiply_divide_unit
// A command is taken at a clock edge where start is high and busy is low; busy
// then stays high until the unit is ready for the next command. Every command
// returns exactly one result beat, shown for one cycle with o_done high, in the
// first cycle that busy is low again; the receiver must take it then. MFLO/MFHI
// as well as MTLO/MTHI and unused codes go through decode and commit only;
// multiplies form four 32x32 partial products through one multiplier, then
// take two signed-correction steps; divides use the restoring divider that
// retires one quotient bit per cycle, then fixes the signs.
//------------------------------------------------------------------------------
module hi_lo_multiply_divide_unit
    import hlmdu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [DATA_W-1:0] i_source_a,
    input  logic [DATA_W-1:0] i_source_b,
    input  logic [REG_W-1:0]  i_dest_index,
    output logic              o_done,
    output logic              o_write_enable,
    output logic [REG_W-1:0]  o_write_index,
    output logic [DATA_W-1:0] o_write_value
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    hlmdu_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (busy)
    );

    hlmdu_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_mode         (i_mode),
        .i_source_a     (i_source_a),
        .i_source_b     (i_source_b),
        .i_dest_index   (i_dest_index),
        .o_status       (dp_status),
        .o_done         (o_done),
        .o_write_enable (o_write_enable),
        .o_write_index  (o_write_index),
        .o_write_value  (o_write_value)
    );

`ifndef SYNTHESIS
    // A result beat only follows a command that was in progress.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result beat without a command in progress");

    // An accepted command always makes the unit busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but unit not busy");

    // A register write is only signaled on a result beat.
    a_we_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_write_enable |-> (o_done && o_write_index != '0))
        else $error("write enable outside a result beat or to register zero");
`endif

endmodule

### src/hlmdu_ctrl.sv
//------------------------------------------------------------------------------
// hlmdu_ctrl
// Sequencer: accepts a command, then steps the datapath through the
// multiply, divide or move phases and ends with a commit.
//------------------------------------------------------------------------------
module hlmdu_ctrl
    import hlmdu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        unique case (r_state)
            S_IDLE: begin
                n_count = '0;
                if (i_start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_count = '0;
                unique case (i_status.kind)
                    K_MUL:   n_state = S_MUL;
                    K_DIV:   n_state = S_DIV;
                    default: n_state = S_COMMIT;
                endcase
            end
            S_MUL: begin
                if (r_count == MUL_LAST) begin
                    n_state = S_MUL_CORR;
                    n_count = '0;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            S_MUL_CORR: begin
                if (r_count == CORR_LAST) begin
                    n_state = S_COMMIT;
                    n_count = '0;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            S_DIV: begin
                if (r_count == DIV_LAST) begin
                    n_state = S_DIV_FIX;
                    n_count = '0;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            S_DIV_FIX: n_state = S_COMMIT;
            S_COMMIT:  n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.idx = r_count;
        o_busy    = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.op = i_start ? DP_LOAD : DP_NOP;
                o_busy   = 1'b0;
            end
            S_DECODE:   o_cmd.op = DP_NOP;
            S_MUL:      o_cmd.op = DP_MUL_STEP;
            S_MUL_CORR: o_cmd.op = DP_MUL_CORR;
            S_DIV:      o_cmd.op = DP_DIV_STEP;
            S_DIV_FIX:  o_cmd.op = DP_DIV_FIX;
            S_COMMIT:   o_cmd.op = DP_COMMIT;
            default:    o_cmd.op = DP_NOP;
        endcase
    end

endmodule

### src/hlmdu_dp.sv
//------------------------------------------------------------------------------
// hlmdu_dp
// Datapath: operand capture, 32x32 partial-product multiplier with a 128-bit
// accumulator, restoring divider, HI/LO registers and the result beat.
//------------------------------------------------------------------------------
module hlmdu_dp
    import hlmdu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [DATA_W-1:0] i_source_a,
    input  logic [DATA_W-1:0] i_source_b,
    input  logic [REG_W-1:0]  i_dest_index,
    output t_dp_status        o_status,
    output logic              o_done,
    output logic              o_write_enable,
    output logic [REG_W-1:0]  o_write_index,
    output logic [DATA_W-1:0] o_write_value
);

    function automatic logic [DATA_W-1:0] sext32(input logic [HALF_W-1:0] v);
        return {{HALF_W{v[HALF_W-1]}}, v};
    endfunction

    // Operand decode at capture time.
    logic              is32_in, sgn_in, neg_a_in, neg_b_in;
    logic [DATA_W-1:0] ext_a, ext_b, mag_a, mag_b;
    t_kind             kind_in;

    always_comb begin
        is32_in = (i_mode == MODE_MULT) || (i_mode == MODE_MULTU) ||
                  (i_mode == MODE_DIV)  || (i_mode == MODE_DIVU);
        sgn_in  = (i_mode == MODE_MULT) || (i_mode == MODE_DMULT) ||
                  (i_mode == MODE_DIV)  || (i_mode == MODE_DDIV);
        ext_a   = is32_in ? {{HALF_W{sgn_in & i_source_a[HALF_W-1]}},
                             i_source_a[HALF_W-1:0]} : i_source_a;
        ext_b   = is32_in ? {{HALF_W{sgn_in & i_source_b[HALF_W-1]}},
                             i_source_b[HALF_W-1:0]} : i_source_b;
        neg_a_in = sgn_in & ext_a[DATA_W-1];
        neg_b_in = sgn_in & ext_b[DATA_W-1];
        mag_a   = neg_a_in ? (~ext_a + DATA_W'(1)) : ext_a;
        mag_b   = neg_b_in ? (~ext_b + DATA_W'(1)) : ext_b;
        case (i_mode) inside
            MODE_MULT, MODE_MULTU, MODE_DMULT, MODE_DMULTU: kind_in = K_MUL;
            MODE_DIV, MODE_DIVU, MODE_DDIV, MODE_DDIVU:     kind_in = K_DIV;
            default:                                        kind_in = K_MOVE;
        endcase
    end

    logic [MODE_W-1:0]   r_mode;
    logic [REG_W-1:0]    r_dest;
    logic                r_is32, r_neg_a, r_neg_b;
    t_kind               r_kind;
    logic [DATA_W-1:0]   r_opa, r_opb, r_mb;
    logic [2*DATA_W-1:0] r_acc;
    logic [DATA_W-1:0]   r_pp;
    logic [1:0]          r_pp_k;
    logic [DATA_W-1:0]   r_hi, r_lo;
    logic                r_done, r_we;
    logic [REG_W-1:0]    r_widx;
    logic [DATA_W-1:0]   r_wval;

    assign o_status.kind = r_kind;

    // Multiplier: idx[1] picks the half of A, idx[0] the half of B.
    logic [HALF_W-1:0]   mul_x, mul_y;
    logic [2*DATA_W-1:0] pp_aligned;

    always_comb begin
        mul_x = i_cmd.idx[1] ? r_opa[DATA_W-1:HALF_W] : r_opa[HALF_W-1:0];
        mul_y = i_cmd.idx[0] ? r_opb[DATA_W-1:HALF_W] : r_opb[HALF_W-1:0];
        case (r_pp_k)
            2'd0:    pp_aligned = {{DATA_W{1'b0}}, r_pp};
            2'd3:    pp_aligned = {r_pp, {DATA_W{1'b0}}};
            default: pp_aligned = {{HALF_W{1'b0}}, r_pp, {HALF_W{1'b0}}};
        endcase
    end

    // One restoring divide step: shift in the next dividend bit, try a subtract.
    logic [DATA_W:0]   rem_sh, rem_diff;
    logic              rem_ge;
    logic [DATA_W-1:0] quo_fix, rem_fix;

    always_comb begin
        rem_sh   = {r_acc[2*DATA_W-1:DATA_W], r_acc[DATA_W-1]};
        rem_ge   = rem_sh >= {1'b0, r_mb};
        rem_diff = rem_sh - {1'b0, r_mb};
        quo_fix  = (r_neg_a ^ r_neg_b) ? (~r_acc[DATA_W-1:0] + DATA_W'(1))
                                       : r_acc[DATA_W-1:0];
        rem_fix  = r_neg_a ? (~r_acc[2*DATA_W-1:DATA_W] + DATA_W'(1))
                           : r_acc[2*DATA_W-1:DATA_W];
    end

    // Values the commit step places in HI and LO for arithmetic operations.
    logic [DATA_W-1:0] arith_hi, arith_lo;

    always_comb begin
        if (r_is32) begin
            arith_lo = sext32(r_acc[HALF_W-1:0]);
            arith_hi = (r_kind == K_MUL) ? sext32(r_acc[DATA_W-1:HALF_W])
                                         : sext32(r_acc[DATA_W+HALF_W-1:DATA_W]);
        end else begin
            arith_lo = r_acc[DATA_W-1:0];
            arith_hi = r_acc[2*DATA_W-1:DATA_W];
        end
    end

    // Architectural HI/LO and the result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi   <= '0;
            r_lo   <= '0;
            r_done <= 1'b0;
            r_we   <= 1'b0;
        end else begin
            r_done <= (i_cmd.op == DP_COMMIT);
            r_we   <= 1'b0;
            if (i_cmd.op == DP_COMMIT) begin
                case (r_mode) inside
                    MODE_MFLO, MODE_MFHI: r_we <= (r_dest != '0);
                    MODE_MTLO: r_lo <= r_opa;
                    MODE_MTHI: r_hi <= r_opa;
                    MODE_MULT, MODE_MULTU, MODE_DMULT, MODE_DMULTU,
                    MODE_DIV, MODE_DIVU, MODE_DDIV, MODE_DDIVU: begin
                        r_hi <= arith_hi;
                        r_lo <= arith_lo;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_LOAD: begin
                r_mode  <= i_mode;
                r_dest  <= i_dest_index;
                r_is32  <= is32_in;
                r_neg_a <= neg_a_in;
                r_neg_b <= neg_b_in;
                r_kind  <= kind_in;
                r_opa   <= ext_a;
                r_opb   <= ext_b;
                r_mb    <= mag_b;
                r_acc   <= (kind_in == K_DIV) ? {{DATA_W{1'b0}}, mag_a} : '0;
            end
            DP_MUL_STEP: begin
                if (i_cmd.idx[CNT_W-1:2] == '0) begin
                    r_pp   <= {{HALF_W{1'b0}}, mul_x} * {{HALF_W{1'b0}}, mul_y};
                    r_pp_k <= i_cmd.idx[1:0];
                end
                if (i_cmd.idx != '0) begin
                    r_acc <= r_acc + pp_aligned;
                end
            end
            DP_MUL_CORR: begin
                // Signed 128-bit product from the unsigned one: subtract the
                // other operand from the high half for each negative operand.
                if (i_cmd.idx[0] == 1'b0 && r_neg_a) begin
                    r_acc[2*DATA_W-1:DATA_W] <= r_acc[2*DATA_W-1:DATA_W] - r_opb;
                end
                if (i_cmd.idx[0] == 1'b1 && r_neg_b) begin
                    r_acc[2*DATA_W-1:DATA_W] <= r_acc[2*DATA_W-1:DATA_W] - r_opa;
                end
            end
            DP_DIV_STEP: begin
                r_acc <= {rem_ge ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0],
                          r_acc[DATA_W-2:0], rem_ge};
            end
            DP_DIV_FIX: begin
                r_acc <= {rem_fix, quo_fix};
            end
            DP_COMMIT: begin
                if ((r_mode == MODE_MFLO || r_mode == MODE_MFHI) && r_dest != '0) begin
                    r_widx <= r_dest;
                    r_wval <= (r_mode == MODE_MFLO) ? r_lo : r_hi;
                end else begin
                    r_widx <= '0;
                    r_wval <= '0;
                end
            end
            default: ;
        endcase
    end

    assign o_done         = r_done;
    assign o_write_enable = r_we;
    assign o_write_index  = r_widx;
    assign o_write_value  = r_wval;

endmodule

### dv/hi_lo_multiply_divide_unit_tb.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// hi_lo_multiply_divide_unit_tb
// Self-checking bench for the HI/LO multiply/divide unit. A scoreboard keeps its
// own HI and LO, predicts the write-back of every accepted command, and checks
// each o_done beat against the oldest prediction. A directed set of corner cases
// comes first, then random commands with random idle bursts on the start side.
//------------------------------------------------------------------------------
module hi_lo_multiply_divide_unit_tb;
    import hlmdu_pkg::*;

    localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] SIGN_BIT = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 4'd12;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 4'd15;
    localparam int RANDOM_CMDS = 500;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic              we;
        logic [REG_W-1:0]  idx;
        logic [DATA_W-1:0] val;
    } t_writeback;

    class hilo_scoreboard;
        logic [DATA_W-1:0] hi_reg;
        logic [DATA_W-1:0] lo_reg;
        t_writeback        writeback_q[$];
        int unsigned       err_cnt;

        function new();
            hi_reg  = '0;
            lo_reg  = '0;
            err_cnt = 0;
        endfunction

        static function logic [DATA_W-1:0] sext32(logic [DATA_W-1:0] v);
            return {{HALF_W{v[HALF_W-1]}}, v[HALF_W-1:0]};
        endfunction

        static function void divide_unsigned(input logic [DATA_W-1:0] a, b,
                                             output logic [DATA_W-1:0] q, r);
            if (b == '0) begin
                q = ALL_ONES;
                r = a;
            end else begin
                q = a / b;
                r = a % b;
            end
        endfunction

        // Quotient truncates toward zero; the remainder follows the dividend's sign.
        static function void divide_signed(input logic [DATA_W-1:0] a, b,
                                           output logic [DATA_W-1:0] q, r);
            logic [DATA_W-1:0] mag_a, mag_b, qq, rr;
            if (b == '0) begin
                q = a[DATA_W-1] ? DATA_W'(1) : ALL_ONES;
                r = a;
            end else if (a == SIGN_BIT && b == ALL_ONES) begin
                q = a;
                r = '0;
            end else begin
                mag_a = a[DATA_W-1] ? ('0 - a) : a;
                mag_b = b[DATA_W-1] ? ('0 - b) : b;
                qq = mag_a / mag_b;
                rr = mag_a % mag_b;
                q = (a[DATA_W-1] != b[DATA_W-1]) ? ('0 - qq) : qq;
                r = a[DATA_W-1] ? ('0 - rr) : rr;
            end
        endfunction

        // Update HI/LO for an accepted command and queue the write-back it causes.
        function void note_command(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] a, b,
                                   logic [REG_W-1:0] rd);
            t_writeback        wb;
            logic [DATA_W-1:0] p64, q, r;
            logic [2*DATA_W-1:0] p128;
            wb = '0;
            case (mode)
                MODE_MFLO, MODE_MFHI: begin
                    if (rd != '0) begin
                        wb.we  = 1'b1;
                        wb.idx = rd;
                        wb.val = (mode == MODE_MFLO) ? lo_reg : hi_reg;
                    end
                end
                MODE_MTLO: lo_reg = a;
                MODE_MTHI: hi_reg = a;
                MODE_MULT, MODE_MULTU: begin
                    if (mode == MODE_MULT)
                        p64 = sext32(a) * sext32(b);
                    else
                        p64 = {{HALF_W{1'b0}}, a[HALF_W-1:0]} * {{HALF_W{1'b0}}, b[HALF_W-1:0]};
                    hi_reg = sext32(p64 >> HALF_W);
                    lo_reg = sext32(p64);
                end
                MODE_DMULT, MODE_DMULTU: begin
                    if (mode == MODE_DMULT)
                        p128 = {{DATA_W{a[DATA_W-1]}}, a} * {{DATA_W{b[DATA_W-1]}}, b};
                    else
                        p128 = {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
                    hi_reg = p128[2*DATA_W-1:DATA_W];
                    lo_reg = p128[DATA_W-1:0];
                end
                MODE_DIV, MODE_DIVU: begin
                    if (mode == MODE_DIV)
                        divide_signed(sext32(a), sext32(b), q, r);
                    else
                        divide_unsigned({{HALF_W{1'b0}}, a[HALF_W-1:0]},
                                        {{HALF_W{1'b0}}, b[HALF_W-1:0]}, q, r);
                    lo_reg = sext32(q);
                    hi_reg = sext32(r);
                end
                MODE_DDIV:  divide_signed(a, b, lo_reg, hi_reg);
                MODE_DDIVU: divide_unsigned(a, b, lo_reg, hi_reg);
                default: ;
            endcase
            writeback_q.push_back(wb);
        endfunction

        function void check_writeback(logic we, logic [REG_W-1:0] idx,
                                      logic [DATA_W-1:0] val);
            t_writeback exp_wb;
            if (writeback_q.size() == 0) begin
                $error("write-back beat with no command outstanding");
                err_cnt++;
                return;
            end
            exp_wb = writeback_q.pop_front();
            if (we !== exp_wb.we) begin
                $error("write_enable: expected %0d, got %0d", exp_wb.we, we);
                err_cnt++;
            end
            if (idx !== exp_wb.idx) begin
                $error("write_index: expected %0d, got %0d", exp_wb.idx, idx);
                err_cnt++;
            end
            if (val !== exp_wb.val) begin
                $error("write_value: expected %h, got %h", exp_wb.val, val);
                err_cnt++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [MODE_W-1:0] i_mode;
    logic [DATA_W-1:0] i_source_a;
    logic [DATA_W-1:0] i_source_b;
    logic [REG_W-1:0]  i_dest_index;
    logic              o_done;
    logic              o_write_enable;
    logic [REG_W-1:0]  o_write_index;
    logic [DATA_W-1:0] o_write_value;

    hilo_scoreboard sb;

    hi_lo_multiply_divide_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_source_a     (i_source_a),
        .i_source_b     (i_source_b),
        .i_dest_index   (i_dest_index),
        .o_done         (o_done),
        .o_write_enable (o_write_enable),
        .o_write_index  (o_write_index),
        .o_write_value  (o_write_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Values read right after the edge are the ones the edge sampled.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_writeback(o_write_enable, o_write_index, o_write_value);
    end

    // Present one command and hold it until the edge where busy is low.
    task automatic issue_cmd(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] a, b,
                             logic [REG_W-1:0] rd);
        start        <= 1'b1;
        i_mode       <= mode;
        i_source_a   <= a;
        i_source_b   <= b;
        i_dest_index <= rd;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        sb.note_command(mode, a, b, rd);
    endtask

    task automatic idle_gap(int unsigned n);
        start        <= 1'b0;
        i_mode       <= MODE_W'($urandom);
        i_source_a   <= {$urandom, $urandom};
        i_source_b   <= {$urandom, $urandom};
        i_dest_index <= REG_W'($urandom);
        repeat (n) @(posedge i_clk);
    endtask

    // An arithmetic command followed by a read of the half that matters most.
    task automatic op_and_read(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] a, b,
                               logic [MODE_W-1:0] read_mode);
        issue_cmd(mode, a, b, REG_W'($urandom_range(1, 31)));
        issue_cmd(read_mode, {$urandom, $urandom}, {$urandom, $urandom},
                  REG_W'($urandom_range(1, 31)));
    endtask

    function automatic logic [DATA_W-1:0] pick_operand();
        logic [DATA_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 11))
            0: v = '0;
            1: v = ALL_ONES;
            2: v = SIGN_BIT;
            3: v = DATA_W'($urandom_range(0, 15));
            4: v = '0 - DATA_W'($urandom_range(1, 16));
            5: v[HALF_W-1:0] = 32'h8000_0000;
            6: v[HALF_W-1:0] = 32'hffff_ffff;
            7: v[HALF_W-1:0] = 32'($urandom_range(0, 15));
            8: v[HALF_W-1:0] = '0;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return $urandom_range(0, 1) ? MODE_MFHI : MODE_MFLO;
        else if (r < 45)
            return $urandom_range(0, 1) ? MODE_MTHI : MODE_MTLO;
        else if (r < 65)
            case ($urandom_range(0, 3))
                0: return MODE_MULT;
                1: return MODE_MULTU;
                2: return MODE_DMULT;
                default: return MODE_DMULTU;
            endcase
        else if (r < 95)
            case ($urandom_range(0, 3))
                0: return MODE_DIV;
                1: return MODE_DIVU;
                2: return MODE_DDIV;
                default: return MODE_DDIVU;
            endcase
        return MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
    endfunction

    initial begin
        sb = new();
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_mode       <= MODE_MFLO;
        i_source_a   <= '0;
        i_source_b   <= '0;
        i_dest_index <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners: moves, destination zero, extreme products,
        // divide by zero, signed minimum over minus one, and unused codes.
        issue_cmd(MODE_MTLO, ALL_ONES, '0, 5'd3);
        issue_cmd(MODE_MTHI, SIGN_BIT, ALL_ONES, 5'd0);
        issue_cmd(MODE_MFLO, '0, '0, 5'd31);
        issue_cmd(MODE_MFHI, '0, '0, 5'd0);
        issue_cmd(MODE_MFHI, ALL_ONES, ALL_ONES, 5'd1);
        issue_cmd(MODE_SPARE_FIRST, ALL_ONES, ALL_ONES, 5'd31);
        op_and_read(MODE_MULT, 64'hdead_beef_8000_0000, 64'h1234_5678_7fff_ffff, MODE_MFHI);
        op_and_read(MODE_MULTU, ALL_ONES, ALL_ONES, MODE_MFHI);
        op_and_read(MODE_DMULT, SIGN_BIT, ALL_ONES, MODE_MFLO);
        op_and_read(MODE_DMULTU, ALL_ONES, ALL_ONES, MODE_MFHI);
        op_and_read(MODE_DIV, 64'h0000_0000_8000_0000, 64'h0000_0000_ffff_ffff, MODE_MFLO);
        op_and_read(MODE_DIV, 64'h0000_0000_ffff_fff9, 64'd2, MODE_MFHI);
        op_and_read(MODE_DIVU, 64'h5, 64'hffff_ffff_0000_0000, MODE_MFLO);
        op_and_read(MODE_DDIV, SIGN_BIT, ALL_ONES, MODE_MFLO);
        op_and_read(MODE_DDIV, ALL_ONES - 64'd5, '0, MODE_MFLO);
        issue_cmd(MODE_SPARE_LAST, '0, '0, 5'd7);
        op_and_read(MODE_DDIVU, ALL_ONES, 64'd7, MODE_MFHI);

        // Random commands; the last fifth runs back to back.
        for (int i = 0; i < RANDOM_CMDS; i++) begin
            if (i < RANDOM_CMDS * 4 / 5 && $urandom_range(0, 3) == 0)
                idle_gap($urandom_range(1, 19));
            issue_cmd(pick_mode(), pick_operand(), pick_operand(),
                      REG_W'($urandom_range(0, 31)));
        end
        start <= 1'b0;

        while (sb.writeback_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.err_cnt == 0 && sb.writeback_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### files.f
src/hlmdu_pkg.sv
src/hlmdu_ctrl.sv
src/hlmdu_dp.sv
src/hi_lo_multiply_divide_unit.sv
dv/hi_lo_multiply_divide_unit_tb.sv
